>>> sv/oal_pkg.sv
package oal_pkg;

   // fixed field widths of the command and response words
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned OP_W     = 3;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned POS_W    = 6;
   localparam int unsigned COUNT_W  = 7;

   // command opcodes (code 7 is unused and answers ok)
   typedef enum logic [OP_W-1:0] {
      OP_INS_HEAD  = 3'd0,
      OP_INS_TAIL  = 3'd1,
      OP_INS_AFTER = 3'd2,
      OP_DEL_HEAD  = 3'd3,
      OP_DEL_TAIL  = 3'd4,
      OP_DEL_KEY   = 3'd5,
      OP_LOCATE    = 3'd6
   } op_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE       = 2'd0,
      S_SEARCH     = 2'd1,
      S_SHIFT_UP   = 2'd2,
      S_SHIFT_DOWN = 2'd3
   } state_type;

   // port strobes of the entry store
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } store_ctl_type;

endpackage

>>> sv/oal_store.sv
module oal_store #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = 6
) (
   input  logic                                clock,
   input  oal_pkg::store_ctl_type              ctl,
   input  logic [AW-1:0]                       wr_addr,
   input  logic signed [oal_pkg::DATA_W-1:0]   wr_data,
   input  logic [AW-1:0]                       rd_addr,
   output logic signed [oal_pkg::DATA_W-1:0]   rd_data
);

   logic signed [oal_pkg::DATA_W-1:0] mem [DEPTH];
   logic signed [oal_pkg::DATA_W-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/ordered_array_list_engine.sv
// Bounded ordered list of signed 32-bit values held in a single-port-read RAM of DEPTH words
// plus an entry count. Each request word carries an opcode (insert at head, insert at tail,
// insert after key, delete at head, delete at tail, delete key, locate) and gets exactly one
// response word with status, position and the count after the command. One command is in
// work at a time and req_stall stays high until it is done. Rejected commands and opcode 7
// answer on the edge they are taken; insert at tail and delete at tail answer from the shift
// state without a walk; a key search reads one entry per cycle through the RAM read port and
// a head insert, head delete or keyed insert/delete then moves one entry per cycle, so the
// length of a command is set by the single RAM read port walking the list. A finished
// response sits in an output register; a new request is taken once that register is free or
// being drained. No clearing pass after reset: only entries below the count are ever read.
module ordered_array_list_engine #(
   parameter int unsigned DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [oal_pkg::OP_W-1:0]              req_opcode,
   input  logic signed [oal_pkg::DATA_W-1:0]     req_key_value,
   input  logic signed [oal_pkg::DATA_W-1:0]     req_new_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [oal_pkg::STATUS_W-1:0]          rsp_status,
   output logic [oal_pkg::POS_W-1:0]             rsp_position,
   output logic [oal_pkg::COUNT_W-1:0]           rsp_count_after
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   oal_pkg::state_type  state_ff, state_in;
   oal_pkg::op_type     op_ff, op_in;
   logic signed [oal_pkg::DATA_W-1:0] key_ff, key_in;
   logic signed [oal_pkg::DATA_W-1:0] val_ff, val_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       rem_ff, rem_in;
   logic [AW-1:0]       ptr_ff, ptr_in;
   logic [AW-1:0]       gap_ff, gap_in;
   logic                pend_ff, pend_in;
   logic [AW-1:0]       pend_addr_ff, pend_addr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   oal_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [oal_pkg::POS_W-1:0]   rsp_position_ff, rsp_position_in;
   logic [oal_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   oal_pkg::store_ctl_type            st_ctl;
   logic [AW-1:0]                     st_wr_addr;
   logic signed [oal_pkg::DATA_W-1:0] st_wr_data;
   logic [AW-1:0]                     st_rd_addr;
   logic signed [oal_pkg::DATA_W-1:0] st_rd_data;

   logic accept;
   logic is_full;
   logic is_empty;
   logic hit;
   logic miss;
   logic issue;
   logic walk_done;

   // entry store
   oal_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .ctl     (st_ctl),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   // handshake and walk conditions
   assign req_stall = (state_ff != oal_pkg::S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign is_full   = (count_ff == CW'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign hit       = (state_ff == oal_pkg::S_SEARCH) && pend_ff && (st_rd_data == key_ff);
   assign walk_done = (rem_ff == '0) && !pend_ff;
   assign miss      = (state_ff == oal_pkg::S_SEARCH) && walk_done;
   assign issue     = (state_ff != oal_pkg::S_IDLE) && !hit && (rem_ff != '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         oal_pkg::S_IDLE: begin
            if (accept) begin
               unique case (oal_pkg::op_type'(req_opcode)) inside
                  oal_pkg::OP_INS_HEAD, oal_pkg::OP_INS_TAIL: begin
                     if (!is_full) state_in = oal_pkg::S_SHIFT_UP;
                  end
                  oal_pkg::OP_INS_AFTER: begin
                     if (!is_full && !is_empty) state_in = oal_pkg::S_SEARCH;
                  end
                  oal_pkg::OP_DEL_HEAD, oal_pkg::OP_DEL_TAIL: begin
                     if (!is_empty) state_in = oal_pkg::S_SHIFT_DOWN;
                  end
                  oal_pkg::OP_DEL_KEY, oal_pkg::OP_LOCATE: begin
                     if (!is_empty) state_in = oal_pkg::S_SEARCH;
                  end
                  default: ;
               endcase
            end
         end
         oal_pkg::S_SEARCH: begin
            if (hit) begin
               unique case (op_ff) inside
                  oal_pkg::OP_LOCATE:  state_in = oal_pkg::S_IDLE;
                  oal_pkg::OP_DEL_KEY: state_in = oal_pkg::S_SHIFT_DOWN;
                  default:             state_in = oal_pkg::S_SHIFT_UP;
               endcase
            end else if (miss) begin
               state_in = oal_pkg::S_IDLE;
            end
         end
         oal_pkg::S_SHIFT_UP, oal_pkg::S_SHIFT_DOWN: begin
            if (walk_done) state_in = oal_pkg::S_IDLE;
         end
         default: state_in = oal_pkg::S_IDLE;
      endcase
   end

   // datapath, store strobes and response
   always_comb begin
      op_in           = op_ff;
      key_in          = key_ff;
      val_in          = val_ff;
      count_in        = count_ff;
      rem_in          = rem_ff;
      ptr_in          = ptr_ff;
      gap_in          = gap_ff;
      pend_in         = pend_ff;
      pend_addr_in    = pend_addr_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_status_in   = rsp_status_ff;
      rsp_position_in = rsp_position_ff;
      rsp_count_in    = rsp_count_ff;
      st_ctl          = '0;
      st_wr_addr      = '0;
      st_wr_data      = val_ff;
      st_rd_addr      = ptr_ff;

      unique case (state_ff)
         oal_pkg::S_IDLE: begin
            if (accept) begin
               op_in           = oal_pkg::op_type'(req_opcode);
               key_in          = req_key_value;
               val_in          = req_new_value;
               pend_in         = 1'b0;
               rsp_position_in = '0;
               rsp_count_in    = oal_pkg::COUNT_W'(count_ff);
               unique case (oal_pkg::op_type'(req_opcode)) inside
                  oal_pkg::OP_INS_HEAD: begin
                     if (is_full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = oal_pkg::ST_FULL;
                     end else begin
                        gap_in = '0;
                        rem_in = count_ff;
                        ptr_in = AW'(count_ff - CW'(1));
                     end
                  end
                  oal_pkg::OP_INS_TAIL: begin
                     if (is_full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = oal_pkg::ST_FULL;
                     end else begin
                        gap_in = AW'(count_ff);
                        rem_in = '0;
                     end
                  end
                  oal_pkg::OP_INS_AFTER: begin
                     if (is_full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = oal_pkg::ST_FULL;
                     end else if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = oal_pkg::ST_EMPTY;
                     end else begin
                        rem_in = count_ff;
                        ptr_in = '0;
                     end
                  end
                  oal_pkg::OP_DEL_HEAD: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = oal_pkg::ST_EMPTY;
                     end else begin
                        gap_in = '0;
                        rem_in = count_ff - CW'(1);
                        ptr_in = AW'(1);
                     end
                  end
                  oal_pkg::OP_DEL_TAIL: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = oal_pkg::ST_EMPTY;
                     end else begin
                        rem_in = '0;
                     end
                  end
                  oal_pkg::OP_DEL_KEY, oal_pkg::OP_LOCATE: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = oal_pkg::ST_EMPTY;
                     end else begin
                        rem_in = count_ff;
                        ptr_in = '0;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = oal_pkg::ST_OK;
                  end
               endcase
            end
         end

         oal_pkg::S_SEARCH: begin
            // compare the word read last cycle; on no match, read the next one
            if (hit) begin
               pend_in = 1'b0;
               unique case (op_ff) inside
                  oal_pkg::OP_LOCATE: begin
                     rsp_valid_in    = 1'b1;
                     rsp_status_in   = oal_pkg::ST_OK;
                     rsp_position_in = oal_pkg::POS_W'(pend_addr_ff);
                     rsp_count_in    = oal_pkg::COUNT_W'(count_ff);
                  end
                  oal_pkg::OP_DEL_KEY: begin
                     gap_in = pend_addr_ff;
                     rem_in = count_ff - CW'(pend_addr_ff) - CW'(1);
                     ptr_in = pend_addr_ff + AW'(1);
                  end
                  default: begin
                     gap_in = pend_addr_ff + AW'(1);
                     rem_in = count_ff - CW'(pend_addr_ff) - CW'(1);
                     ptr_in = AW'(count_ff - CW'(1));
                  end
               endcase
            end else begin
               if (issue) begin
                  st_ctl.rd_en = 1'b1;
                  ptr_in       = ptr_ff + AW'(1);
                  rem_in       = rem_ff - CW'(1);
                  pend_in      = 1'b1;
                  pend_addr_in = ptr_ff;
               end else begin
                  pend_in = 1'b0;
               end
               if (miss) begin
                  rsp_valid_in    = 1'b1;
                  rsp_status_in   = oal_pkg::ST_NOT_FOUND;
                  rsp_position_in = '0;
                  rsp_count_in    = oal_pkg::COUNT_W'(count_ff);
               end
            end
         end

         oal_pkg::S_SHIFT_UP: begin
            // move entries up one place from the top down, then fill the gap
            if (pend_ff) begin
               st_ctl.wr_en = 1'b1;
               st_wr_addr   = pend_addr_ff + AW'(1);
               st_wr_data   = st_rd_data;
            end
            if (issue) begin
               st_ctl.rd_en = 1'b1;
               ptr_in       = ptr_ff - AW'(1);
               rem_in       = rem_ff - CW'(1);
               pend_in      = 1'b1;
               pend_addr_in = ptr_ff;
            end else begin
               pend_in = 1'b0;
            end
            if (walk_done) begin
               st_ctl.wr_en    = 1'b1;
               st_wr_addr      = gap_ff;
               st_wr_data      = val_ff;
               count_in        = count_ff + CW'(1);
               rsp_valid_in    = 1'b1;
               rsp_status_in   = oal_pkg::ST_OK;
               rsp_position_in = '0;
               rsp_count_in    = oal_pkg::COUNT_W'(count_ff + CW'(1));
            end
         end

         oal_pkg::S_SHIFT_DOWN: begin
            // move entries down one place from the gap upward, then shrink
            if (pend_ff) begin
               st_ctl.wr_en = 1'b1;
               st_wr_addr   = pend_addr_ff - AW'(1);
               st_wr_data   = st_rd_data;
            end
            if (issue) begin
               st_ctl.rd_en = 1'b1;
               ptr_in       = ptr_ff + AW'(1);
               rem_in       = rem_ff - CW'(1);
               pend_in      = 1'b1;
               pend_addr_in = ptr_ff;
            end else begin
               pend_in = 1'b0;
            end
            if (walk_done) begin
               count_in        = count_ff - CW'(1);
               rsp_valid_in    = 1'b1;
               rsp_status_in   = oal_pkg::ST_OK;
               rsp_position_in = '0;
               rsp_count_in    = oal_pkg::COUNT_W'(count_ff - CW'(1));
            end
         end

         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= oal_pkg::S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      key_ff          <= key_in;
      val_ff          <= val_in;
      rem_ff          <= rem_in;
      ptr_ff          <= ptr_in;
      gap_ff          <= gap_in;
      pend_addr_ff    <= pend_addr_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_position_ff <= rsp_position_in;
      rsp_count_ff    <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_count_after = rsp_count_ff;

endmodule

>>> sv/oal_checker.sv
module oal_checker #(
   parameter int unsigned DEPTH = 64
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [oal_pkg::STATUS_W-1:0]        rsp_status,
   input logic [oal_pkg::POS_W-1:0]           rsp_position,
   input logic [oal_pkg::COUNT_W-1:0]         rsp_count_after
);

   // a waiting response word holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_status) && $stable(rsp_position) && $stable(rsp_count_after))
      else $error("response word changed while stalled");

   // no new request word while a response word is blocked
   a_req_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while response is blocked");

   // a full answer reports a full list
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == oal_pkg::ST_FULL) |->
         (rsp_count_after == oal_pkg::COUNT_W'(DEPTH)))
      else $error("full status with wrong count");

   // an empty answer reports an empty list
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == oal_pkg::ST_EMPTY) |-> (rsp_count_after == '0))
      else $error("empty status with nonzero count");

   // failed commands report position zero
   a_fail_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != oal_pkg::ST_OK) |-> (rsp_position == '0))
      else $error("failed command with nonzero position");

endmodule

bind ordered_array_list_engine oal_checker #(
   .DEPTH (DEPTH)
) u_oal_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_position    (rsp_position),
   .rsp_count_after (rsp_count_after)
);

>>> verif/ordered_array_list_engine_tb.sv
module ordered_array_list_engine_tb;

   localparam int unsigned LIST_DEPTH   = 64;
   localparam logic [oal_pkg::OP_W-1:0] OP_UNUSED = 3'd7;
   localparam int unsigned RANDOM_CMDS  = 1000;
   localparam int unsigned SEGMENT_LEN  = 150;
   localparam int unsigned QUIET_TAIL   = 150;
   localparam int unsigned LONG_HOLD    = 300;
   localparam int unsigned HOLD_AFTER   = 300;
   localparam int unsigned REPORT_LIMIT = 10;
   localparam int unsigned POOL_SIZE    = 10;
   localparam int unsigned DRAIN_CYCLES = 2 * LIST_DEPTH + 16;

   typedef struct {
      logic [oal_pkg::OP_W-1:0]   opcode;
      logic [oal_pkg::DATA_W-1:0] key_value;
      logic [oal_pkg::DATA_W-1:0] new_value;
   } list_cmd_type;

   typedef struct {
      oal_pkg::status_type         status;
      logic [oal_pkg::POS_W-1:0]   position;
      logic [oal_pkg::COUNT_W-1:0] count_after;
   } list_reply_type;

   logic                              clock;
   logic                              reset           = 1'b1;
   logic                              req_valid       = 1'b0;
   logic                              req_stall;
   logic [oal_pkg::OP_W-1:0]          req_opcode      = '0;
   logic signed [oal_pkg::DATA_W-1:0] req_key_value   = '0;
   logic signed [oal_pkg::DATA_W-1:0] req_new_value   = '0;
   logic                              rsp_valid;
   logic                              rsp_stall       = 1'b0;
   logic [oal_pkg::STATUS_W-1:0]      rsp_status;
   logic [oal_pkg::POS_W-1:0]         rsp_position;
   logic [oal_pkg::COUNT_W-1:0]       rsp_count_after;

   list_cmd_type   pending_cmds[$];
   list_reply_type expected_replies[$];

   // shadow copy of the list
   logic [oal_pkg::DATA_W-1:0] model_entries [LIST_DEPTH];
   int unsigned                model_count = 0;

   logic [oal_pkg::DATA_W-1:0] value_pool [POOL_SIZE];
   int unsigned total_cmds    = 0;
   int unsigned sent_cmds     = 0;
   int unsigned taken_cmds    = 0;
   int unsigned checked_words = 0;
   int unsigned fail_count    = 0;
   int unsigned peak_count    = 0;
   int unsigned held_cycles   = 0;
   int unsigned status_seen [4];
   int unsigned send_idle     = 0;
   int unsigned recv_idle     = 0;
   bit          long_hold_done = 1'b0;
   logic        quiet_phase;

   assign quiet_phase = (sent_cmds + QUIET_TAIL >= total_cmds);

   ordered_array_list_engine #(
      .DEPTH(LIST_DEPTH)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_key_value  (req_key_value),
      .req_new_value  (req_new_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_position   (rsp_position),
      .rsp_count_after(rsp_count_after)
   );

   // clock generation
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // first entry equal to the key, or the count when absent
   function automatic int unsigned find_first(input logic [oal_pkg::DATA_W-1:0] key);
      int unsigned i;
      for (i = 0; i < model_count; i++) begin
         if (model_entries[i] == key) return i;
      end
      return model_count;
   endfunction

   // open a gap at slot and store the value
   function automatic void open_slot(input int unsigned slot,
                                     input logic [oal_pkg::DATA_W-1:0] value);
      int unsigned i;
      for (i = model_count; i > slot; i--) model_entries[i] = model_entries[i - 1];
      model_entries[slot] = value;
      model_count++;
   endfunction

   // remove the entry at slot, closing the gap
   function automatic void close_slot(input int unsigned slot);
      int unsigned i;
      for (i = slot; i + 1 < model_count; i++) model_entries[i] = model_entries[i + 1];
      model_count--;
   endfunction

   // apply one command word to the shadow list and form the reply
   function automatic list_reply_type apply_command(input logic [oal_pkg::OP_W-1:0] op,
                                                    input logic [oal_pkg::DATA_W-1:0] key,
                                                    input logic [oal_pkg::DATA_W-1:0] value);
      list_reply_type reply;
      int unsigned hit;
      reply.status   = oal_pkg::ST_OK;
      reply.position = '0;
      case (op)
         oal_pkg::OP_INS_HEAD, oal_pkg::OP_INS_TAIL: begin
            if (model_count >= LIST_DEPTH) reply.status = oal_pkg::ST_FULL;
            else open_slot((op == oal_pkg::OP_INS_HEAD) ? 0 : model_count, value);
         end
         oal_pkg::OP_INS_AFTER: begin
            // full is checked before the search
            if (model_count >= LIST_DEPTH) reply.status = oal_pkg::ST_FULL;
            else if (model_count == 0) reply.status = oal_pkg::ST_EMPTY;
            else begin
               hit = find_first(key);
               if (hit >= model_count) reply.status = oal_pkg::ST_NOT_FOUND;
               else open_slot(hit + 1, value);
            end
         end
         oal_pkg::OP_DEL_HEAD, oal_pkg::OP_DEL_TAIL: begin
            if (model_count == 0) reply.status = oal_pkg::ST_EMPTY;
            else if (op == oal_pkg::OP_DEL_HEAD) close_slot(0);
            else model_count--;
         end
         oal_pkg::OP_DEL_KEY, oal_pkg::OP_LOCATE: begin
            if (model_count == 0) reply.status = oal_pkg::ST_EMPTY;
            else begin
               hit = find_first(key);
               if (hit >= model_count) reply.status = oal_pkg::ST_NOT_FOUND;
               else if (op == oal_pkg::OP_DEL_KEY) close_slot(hit);
               else reply.position = hit[oal_pkg::POS_W-1:0];
            end
         end
         default: begin
         end
      endcase
      reply.count_after = model_count[oal_pkg::COUNT_W-1:0];
      status_seen[reply.status]++;
      if (model_count > peak_count) peak_count = model_count;
      return reply;
   endfunction

   task automatic report_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
   endtask

   task automatic add_cmd(input logic [oal_pkg::OP_W-1:0] op,
                          input logic [oal_pkg::DATA_W-1:0] key,
                          input logic [oal_pkg::DATA_W-1:0] value);
      list_cmd_type cmd;
      cmd.opcode    = op;
      cmd.key_value = key;
      cmd.new_value = value;
      pending_cmds.push_back(cmd);
   endtask

   // mostly values from a small pool so that searches hit
   function automatic logic [oal_pkg::DATA_W-1:0] pick_value(input int unsigned pool_pct);
      if ($urandom_range(0, 99) < pool_pct)
         return value_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom;
   endfunction

   // request driver: holds a word until taken, idles in bursts
   always @(negedge clock) begin
      list_cmd_type cmd;
      if (!reset) begin
         if (!(req_valid && taken_cmds < sent_cmds)) begin
            if (send_idle > 0) begin
               send_idle--;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() == 0) begin
               req_valid <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
               send_idle = $urandom_range(0, 13);
               req_valid <= 1'b0;
            end else begin
               cmd = pending_cmds.pop_front();
               req_opcode    <= cmd.opcode;
               req_key_value <= cmd.key_value;
               req_new_value <= cmd.new_value;
               req_valid     <= 1'b1;
               sent_cmds++;
            end
         end
      end
   end

   // response stall: random bursts plus one long hold-off
   always @(negedge clock) begin
      if (!reset) begin
         if (!long_hold_done && taken_cmds >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            recv_idle      = LONG_HOLD;
            held_cycles    = LONG_HOLD;
         end
         if (recv_idle > 0) begin
            recv_idle--;
            rsp_stall <= 1'b1;
         end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            recv_idle = $urandom_range(0, 13);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // monitor: check response words, then predict for taken request words
   always @(posedge clock) begin
      list_reply_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_replies.size() == 0) begin
               report_failure($sformatf(
                  "response word %0d with nothing expected: status %0d position %0d count %0d",
                  checked_words, rsp_status, rsp_position, rsp_count_after));
            end else begin
               want = expected_replies.pop_front();
               if (rsp_status !== want.status || rsp_position !== want.position ||
                   rsp_count_after !== want.count_after) begin
                  report_failure($sformatf(
                     "word %0d: expected status %0d position %0d count %0d, got %0d %0d %0d",
                     checked_words, want.status, want.position, want.count_after,
                     rsp_status, rsp_position, rsp_count_after));
               end
            end
            checked_words++;
         end
         if (req_valid && !req_stall) begin
            expected_replies.push_back(apply_command(req_opcode, req_key_value, req_new_value));
            taken_cmds++;
         end
      end
   end

   // stimulus and end of run
   initial begin
      int unsigned i;
      int unsigned r;
      int unsigned random_made;
      int unsigned ins_pct;
      logic [oal_pkg::OP_W-1:0]   op;
      logic [oal_pkg::DATA_W-1:0] base;

      value_pool[0] = 32'h0000_0000;
      value_pool[1] = 32'hFFFF_FFFF;
      value_pool[2] = 32'h7FFF_FFFF;
      value_pool[3] = 32'h8000_0000;
      for (i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;
      for (i = 0; i < 4; i++) status_seen[i] = 0;

      // empty list cases and the unused opcode
      add_cmd(oal_pkg::OP_DEL_HEAD, $urandom, $urandom);
      add_cmd(oal_pkg::OP_DEL_TAIL, $urandom, $urandom);
      add_cmd(oal_pkg::OP_DEL_KEY, 32'h0000_0000, $urandom);
      add_cmd(oal_pkg::OP_LOCATE, 32'hFFFF_FFFF, $urandom);
      add_cmd(oal_pkg::OP_INS_AFTER, 32'h7FFF_FFFF, $urandom);
      add_cmd(OP_UNUSED, $urandom, $urandom);
      // every insert with extreme values, first match among duplicates
      add_cmd(oal_pkg::OP_INS_HEAD, $urandom, 32'h7FFF_FFFF);
      add_cmd(oal_pkg::OP_INS_TAIL, $urandom, 32'h8000_0000);
      add_cmd(oal_pkg::OP_INS_AFTER, 32'h7FFF_FFFF, 32'h0000_0000);
      add_cmd(oal_pkg::OP_INS_HEAD, $urandom, 32'hFFFF_FFFF);
      add_cmd(oal_pkg::OP_LOCATE, 32'h8000_0000, $urandom);
      add_cmd(oal_pkg::OP_LOCATE, 32'h1234_5678, $urandom);
      add_cmd(oal_pkg::OP_INS_AFTER, 32'h5555_AAAA, $urandom);
      add_cmd(oal_pkg::OP_DEL_KEY, 32'hAAAA_5555, $urandom);
      add_cmd(oal_pkg::OP_INS_AFTER, 32'h8000_0000, 32'h8000_0000);
      add_cmd(oal_pkg::OP_LOCATE, 32'h8000_0000, $urandom);
      add_cmd(oal_pkg::OP_DEL_KEY, 32'h8000_0000, $urandom);
      add_cmd(OP_UNUSED, $urandom, $urandom);
      add_cmd(oal_pkg::OP_DEL_HEAD, $urandom, $urandom);
      add_cmd(oal_pkg::OP_DEL_TAIL, $urandom, $urandom);
      add_cmd(oal_pkg::OP_DEL_KEY, 32'h0000_0000, $urandom);
      add_cmd(oal_pkg::OP_DEL_KEY, 32'h7FFF_FFFF, $urandom);

      // fill to capacity with distinct values, then hit the full list
      base = $urandom & 32'hFFFF_FF00;
      for (i = 0; i < LIST_DEPTH; i++) add_cmd(oal_pkg::OP_INS_TAIL, $urandom, base | i);
      add_cmd(oal_pkg::OP_INS_HEAD, $urandom, $urandom);
      add_cmd(oal_pkg::OP_INS_TAIL, $urandom, $urandom);
      add_cmd(oal_pkg::OP_INS_AFTER, base | 5, $urandom);
      add_cmd(oal_pkg::OP_LOCATE, base | (LIST_DEPTH - 1), $urandom);
      add_cmd(oal_pkg::OP_LOCATE, base, $urandom);
      add_cmd(oal_pkg::OP_DEL_KEY, base | (LIST_DEPTH - 1), $urandom);
      add_cmd(oal_pkg::OP_LOCATE, base | (LIST_DEPTH - 1), $urandom);
      add_cmd(oal_pkg::OP_DEL_KEY, base | 10, $urandom);
      add_cmd(oal_pkg::OP_INS_AFTER, base | 20, pick_value(70));
      add_cmd(oal_pkg::OP_DEL_TAIL, $urandom, $urandom);
      add_cmd(oal_pkg::OP_DEL_HEAD, $urandom, $urandom);
      random_made = LIST_DEPTH + 11;

      // alternating drain and fill segments so the list swings empty to full
      while (random_made < RANDOM_CMDS) begin
         ins_pct = ((random_made / SEGMENT_LEN) % 2 == 0) ? 15 : 70;
         r = $urandom_range(0, 99);
         if (r < 3) op = OP_UNUSED;
         else if (r < 3 + ins_pct) begin
            case ($urandom_range(0, 2))
               0: op = oal_pkg::OP_INS_HEAD;
               1: op = oal_pkg::OP_INS_TAIL;
               default: op = oal_pkg::OP_INS_AFTER;
            endcase
         end else if (r < 15 + ins_pct) op = oal_pkg::OP_LOCATE;
         else begin
            case ($urandom_range(0, 2))
               0: op = oal_pkg::OP_DEL_HEAD;
               1: op = oal_pkg::OP_DEL_TAIL;
               default: op = oal_pkg::OP_DEL_KEY;
            endcase
         end
         add_cmd(op, pick_value(85), pick_value(70));
         if (op != OP_UNUSED) random_made++;
      end
      total_cmds = pending_cmds.size();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (taken_cmds < total_cmds || expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_replies.size() != 0)
         report_failure($sformatf("%0d responses never arrived", expected_replies.size()));

      $display("covered %0d commands: %0d ok, %0d full, %0d empty, %0d not found",
         taken_cmds, status_seen[oal_pkg::ST_OK], status_seen[oal_pkg::ST_FULL],
         status_seen[oal_pkg::ST_EMPTY], status_seen[oal_pkg::ST_NOT_FOUND]);
      $display("peak fill %0d of %0d entries, one response hold-off of %0d cycles, %0d failures",
         peak_count, LIST_DEPTH, held_cycles, fail_count);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("watchdog expired after %0d of %0d commands", taken_cmds, total_cmds);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
